// ----- rtl/spq_pkg.sv -----
// Shared types for the sorted priority queue: request/result structs,
// operation and status codes, and the controller state encoding.
// No dependencies.
package spq_pkg;

  // Operation codes carried in a request
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_JUMP   = 2'd2,
    OP_QUERY  = 2'd3
  } spq_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  // One request on the input channel
  typedef struct packed {
    spq_op_t            opcode;
    logic signed [31:0] priority_req;
    logic signed [31:0] payload;
  } spq_req_t;

  // One result on the output channel
  typedef struct packed {
    logic signed [31:0] removed_data;
    spq_status_t        status;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] middle_data;
    logic signed [31:0] tail_data;
    logic signed [31:0] head_data;
  } spq_rsp_t;

  // One stored queue entry
  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] data;
  } spq_entry_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_RM_RD,
    S_RM_TAKE,
    S_JMP_RD,
    S_JMP_CALC,
    S_RP_HEAD,
    S_RP_MID,
    S_RP_TAIL,
    S_RP_LAST,
    S_OUT
  } spq_state_t;

endpackage

// ----- rtl/sorted_priority_queue_unit.sv -----
// Sorted priority queue: entries live in one synchronous RAM used as a ring,
// a sequencer does insertion shifts, pops and the head/middle/tail readout.
// Depends on spq_pkg.
// Sequence per request: query and full drop go straight to the readout, which is
// skipped when the queue is empty; remove reads and pops the head first; insert
// walks from the tail, moving each larger entry one slot back, unless it is empty;
// jump reads the head to form its priority (0 when empty), then inserts likewise.
// One request at a time: the next is accepted the cycle after the result is
// registered; a stalled result holds the input. Reset empties the queue and clears out_valid only.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_rsp_t out_rsp
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);

  // Logical queue position to RAM address, relative to the ring head
  function automatic logic [IDXW-1:0] phys(input logic [IDXW-1:0] head,
                                           input logic [IDXW-1:0] idx);
    logic [IDXW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (IDXW+1)'(CAPACITY)) sum = sum - (IDXW+1)'(CAPACITY);
    return sum[IDXW-1:0];
  endfunction

  // Entry storage
  spq_entry_t mem [CAPACITY];
  spq_entry_t rd_q;
  logic       rd_en;
  logic [IDXW-1:0] rd_addr;
  logic       wr_en;
  logic [IDXW-1:0] wr_addr;
  spq_entry_t wr_data;

  // Control registers
  spq_state_t      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [IDXW-1:0] head_r, head_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Working registers for the request in progress
  spq_op_t            op_r, op_nxt;
  logic signed [31:0] prio_r, prio_nxt;
  logic signed [31:0] data_r, data_nxt;
  logic [IDXW-1:0]    k_r, k_nxt;
  spq_status_t        status_r, status_nxt;
  logic signed [31:0] removed_r, removed_nxt;
  logic signed [31:0] head_d_r, head_d_nxt;
  logic signed [31:0] mid_d_r, mid_d_nxt;
  logic signed [31:0] tail_d_r, tail_d_nxt;
  spq_rsp_t           out_rsp_r, out_rsp_nxt;

  // Derived indexes
  logic [CNTW-1:0] cnt_half;
  logic [CNTW-1:0] cnt_dec;
  logic [IDXW-1:0] mid_idx;
  logic [IDXW-1:0] tail_idx;
  logic [IDXW-1:0] k_dec;
  logic [31:0]     cnt_ext;
  logic            full;
  logic            empty;

  assign cnt_half = cnt_r >> 1;
  assign cnt_dec  = cnt_r - CNTW'(1);
  assign mid_idx  = cnt_half[IDXW-1:0];
  assign tail_idx = cnt_dec[IDXW-1:0];
  assign k_dec    = k_r - IDXW'(1);
  assign cnt_ext  = 32'(cnt_r);
  assign full     = (cnt_r == CNTW'(CAPACITY));
  assign empty    = (cnt_r == '0);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Sequencer: next state, RAM accesses and working values
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    op_nxt      = op_r;
    prio_nxt    = prio_r;
    data_nxt    = data_r;
    k_nxt       = k_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    head_d_nxt  = head_d_r;
    mid_d_nxt   = mid_d_r;
    tail_d_nxt  = tail_d_r;
    out_rsp_nxt = out_rsp_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_req.opcode;
          prio_nxt    = in_req.priority_req;
          data_nxt    = in_req.payload;
          status_nxt  = ST_OK;
          removed_nxt = '0;
          k_nxt       = cnt_r[IDXW-1:0];
          unique case (in_req.opcode)
            OP_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RP_HEAD;
              end else if (empty) begin
                state_nxt = S_INS_PUT;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RP_HEAD;
              end else begin
                state_nxt = S_RM_RD;
              end
            end
            OP_JUMP: begin
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RP_HEAD;
              end else if (empty) begin
                prio_nxt  = '0;
                state_nxt = S_INS_PUT;
              end else begin
                state_nxt = S_JMP_RD;
              end
            end
            OP_QUERY: state_nxt = S_RP_HEAD;
            default:  state_nxt = S_RP_HEAD;
          endcase
        end
      end

      // Insertion walks from the tail toward the head
      S_INS_RD: begin
        rd_en     = 1'b1;
        rd_addr   = phys(head_r, k_dec);
        state_nxt = S_INS_CMP;
      end

      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, k_r);
        if (prio_r < rd_q.prio) begin
          // displaced entry moves one slot back
          wr_data = rd_q;
          k_nxt   = k_dec;
          state_nxt = (k_dec == '0) ? S_INS_PUT : S_INS_RD;
        end else begin
          wr_data.prio = prio_r;
          wr_data.data = data_r;
          cnt_nxt   = cnt_r + CNTW'(1);
          state_nxt = S_RP_HEAD;
        end
      end

      S_INS_PUT: begin
        wr_en        = 1'b1;
        wr_addr      = phys(head_r, k_r);
        wr_data.prio = prio_r;
        wr_data.data = data_r;
        cnt_nxt      = cnt_r + CNTW'(1);
        state_nxt    = S_RP_HEAD;
      end

      // Pop: fetch head, then advance the ring
      S_RM_RD: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_RM_TAKE;
      end

      S_RM_TAKE: begin
        removed_nxt = rd_q.data;
        head_nxt    = phys(head_r, IDXW'(1));
        cnt_nxt     = cnt_dec;
        state_nxt   = S_RP_HEAD;
      end

      // Jump: new priority is one below the head's, saturating
      S_JMP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_JMP_CALC;
      end

      S_JMP_CALC: begin
        if (rd_q.prio == 32'sh8000_0000) prio_nxt = rd_q.prio;
        else prio_nxt = rd_q.prio - 32'sd1;
        state_nxt = S_INS_RD;
      end

      // Readout of head, middle and tail, one RAM read per cycle
      S_RP_HEAD: begin
        if (empty) begin
          head_d_nxt = '0;
          mid_d_nxt  = '0;
          tail_d_nxt = '0;
          state_nxt  = S_OUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = S_RP_MID;
        end
      end

      S_RP_MID: begin
        head_d_nxt = rd_q.data;
        rd_en      = 1'b1;
        rd_addr    = phys(head_r, mid_idx);
        state_nxt  = S_RP_TAIL;
      end

      S_RP_TAIL: begin
        mid_d_nxt = rd_q.data;
        rd_en     = 1'b1;
        rd_addr   = phys(head_r, tail_idx);
        state_nxt = S_RP_LAST;
      end

      S_RP_LAST: begin
        tail_d_nxt = rd_q.data;
        state_nxt  = S_OUT;
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_rsp_nxt.removed_data = removed_r;
          out_rsp_nxt.status       = status_r;
          out_rsp_nxt.entry_count  = cnt_ext[4:0];
          out_rsp_nxt.is_empty     = empty;
          out_rsp_nxt.middle_data  = mid_d_r;
          out_rsp_nxt.tail_data    = tail_d_r;
          out_rsp_nxt.head_data    = head_d_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    prio_r    <= prio_nxt;
    data_r    <= data_nxt;
    k_r       <= k_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    head_d_r  <= head_d_nxt;
    mid_d_r   <= mid_d_nxt;
    tail_d_r  <= tail_d_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule
